>>> hw/rtl/bspd_pkg.sv
// ----------------------------------------------------------------------------
// Sensor packet deframer package
// Shared constants, codes and types for the deframer block.
// ----------------------------------------------------------------------------
package bspd_pkg;

   // Frame buffer geometry.
   localparam int MAX_FRAME = 20;
   localparam int FILL_W    = $clog2(MAX_FRAME + 1);
   localparam int IDX_W     = $clog2(MAX_FRAME);
   localparam int LEN_W     = 5;
   localparam int CMP_W     = (FILL_W > LEN_W) ? FILL_W : LEN_W;
   localparam int IDLE_W    = 16;

   // Result field widths.
   localparam int OUT_LEN_W = 5;
   localparam int OUT_IDX_W = 5;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_LEN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_LEN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGNET_LEN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_QUAT_LEN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCATION_LEN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT      = 3'd5;

   localparam logic [LEN_W-1:0]  RST_ACCEL_LEN    = 5'd15;
   localparam logic [LEN_W-1:0]  RST_GYRO_LEN     = 5'd15;
   localparam logic [LEN_W-1:0]  RST_MAGNET_LEN   = 5'd15;
   localparam logic [LEN_W-1:0]  RST_QUAT_LEN     = 5'd19;
   localparam logic [LEN_W-1:0]  RST_LOCATION_LEN = 5'd15;
   localparam logic [IDLE_W-1:0] RST_TIMEOUT      = 16'd10;

   // Input command codes.
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Frame characters.
   localparam logic [7:0] START_CHAR    = 8'h21;  // '!'
   localparam logic [7:0] TYPE_ACCEL    = 8'h41;  // 'A'
   localparam logic [7:0] TYPE_GYRO     = 8'h47;  // 'G'
   localparam logic [7:0] TYPE_MAGNET   = 8'h4D;  // 'M'
   localparam logic [7:0] TYPE_QUAT     = 8'h51;  // 'Q'
   localparam logic [7:0] TYPE_LOCATION = 8'h4C;  // 'L'

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_DATA   = 2'd1,
      ST_BAD_START = 2'd2,
      ST_CHECKSUM  = 2'd3
   } status_type;

   typedef enum logic {
      S_COLLECT,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [LEN_W-1:0]  accel_len;
      logic [LEN_W-1:0]  gyro_len;
      logic [LEN_W-1:0]  magnet_len;
      logic [LEN_W-1:0]  quat_len;
      logic [LEN_W-1:0]  location_len;
      logic [IDLE_W-1:0] timeout;
   } csr_cfg_type;

   // Controller to datapath.
   typedef struct packed {
      logic take;    // input transaction accepted
      logic emit;    // load the next result into the output register
      logic finish;  // the final result is being loaded
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic close_hit;  // the offered input closes the frame
      logic emit_last;  // the result about to be emitted is the final one
   } dp_stat_type;

endpackage

>>> hw/rtl/bspd_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying received bytes and idle ticks.
// ----------------------------------------------------------------------------
interface bspd_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] rx_byte;

   modport source (output valid, output cmd, output rx_byte, input ready);
   modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

>>> hw/rtl/bspd_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying deframed bytes and frame status.
// ----------------------------------------------------------------------------
interface bspd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [4:0] frame_length;
   logic [4:0] byte_index;
   logic [7:0] frame_byte;
   logic       last;

   modport source (output valid, output status, output frame_length, output byte_index,
                   output frame_byte, output last, input ready);
   modport sink   (input valid, input status, input frame_length, input byte_index,
                   input frame_byte, input last, output ready);
endinterface

>>> hw/rtl/bspd_csr.sv
// ----------------------------------------------------------------------------
// Deframer configuration registers
// Frame length per type byte and the idle timeout.
// ----------------------------------------------------------------------------
module bspd_csr import bspd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output csr_cfg_type           cfg
);

   csr_cfg_type cfg_ff;
   csr_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ACCEL_LEN:    cfg_in.accel_len    = csr_wdata[LEN_W-1:0];
            CSR_GYRO_LEN:     cfg_in.gyro_len     = csr_wdata[LEN_W-1:0];
            CSR_MAGNET_LEN:   cfg_in.magnet_len   = csr_wdata[LEN_W-1:0];
            CSR_QUAT_LEN:     cfg_in.quat_len     = csr_wdata[LEN_W-1:0];
            CSR_LOCATION_LEN: cfg_in.location_len = csr_wdata[LEN_W-1:0];
            CSR_TIMEOUT:      cfg_in.timeout      = csr_wdata[IDLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_len    <= RST_ACCEL_LEN;
         cfg_ff.gyro_len     <= RST_GYRO_LEN;
         cfg_ff.magnet_len   <= RST_MAGNET_LEN;
         cfg_ff.quat_len     <= RST_QUAT_LEN;
         cfg_ff.location_len <= RST_LOCATION_LEN;
         cfg_ff.timeout      <= RST_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/bspd_ctrl.sv
// ----------------------------------------------------------------------------
// Deframer controller
// Collects input transactions and sequences the emission of a closed frame.
// ----------------------------------------------------------------------------
module bspd_ctrl import bspd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_COLLECT: begin
            if (req_valid && stat.close_hit) state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free && stat.emit_last) state_in = S_COLLECT;
         end
         default: state_in = S_COLLECT;
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready  = 1'b0;
      cmd.emit   = 1'b0;
      case (state_ff)
         S_COLLECT: req_ready = 1'b1;
         S_EMIT:    cmd.emit  = out_free;
         default: ;
      endcase
      cmd.take   = req_valid && req_ready;
      cmd.finish = cmd.emit && stat.emit_last;
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_COLLECT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/bspd_dp.sv
// ----------------------------------------------------------------------------
// Deframer datapath
// Frame buffer, running checksum, idle counter and the result register.
// ----------------------------------------------------------------------------
module bspd_dp import bspd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_cmd,
   input  logic [7:0]           req_rx_byte,
   input  csr_cfg_type          cfg,
   input  dp_cmd_type           cmd,
   output dp_stat_type          stat,
   output logic [1:0]           rsp_status,
   output logic [OUT_LEN_W-1:0] rsp_frame_length,
   output logic [OUT_IDX_W-1:0] rsp_byte_index,
   output logic [7:0]           rsp_frame_byte,
   output logic                 rsp_last
);

   logic [7:0]        store_ff [MAX_FRAME];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        sum_ff, sum_in;
   logic [7:0]        prev_sum_ff, prev_sum_in;
   logic [7:0]        last_ff, last_in;
   logic [7:0]        first_ff, first_in;
   logic [7:0]        type_ff, type_in;
   logic [IDLE_W-1:0] idle_ff, idle_in;
   logic [IDX_W-1:0]  emit_idx_ff, emit_idx_in;

   logic [1:0]           rsp_status_ff;
   logic [OUT_LEN_W-1:0] rsp_frame_length_ff;
   logic [OUT_IDX_W-1:0] rsp_byte_index_ff;
   logic [7:0]           rsp_frame_byte_ff;
   logic                 rsp_last_ff;

   logic              is_byte;
   logic              restart;
   logic [FILL_W-1:0] wr_idx;
   logic [FILL_W-1:0] fill_next;
   logic [7:0]        type_sel;
   logic [LEN_W-1:0]  type_len;
   logic [7:0]        sum_base;
   logic              byte_close;
   logic              tick_close;
   status_type        emit_status;
   logic              emit_ok;

   assign is_byte  = (req_cmd == CMD_BYTE);
   assign restart  = (req_rx_byte == START_CHAR);
   assign wr_idx   = restart ? '0 : fill_ff;
   assign fill_next = wr_idx + FILL_W'(1);

   // The type byte is the incoming one when it lands at position 1.
   assign type_sel = (wr_idx == FILL_W'(1)) ? req_rx_byte : type_ff;
   assign sum_base = (restart || fill_ff == '0) ? 8'd0 : sum_ff;

   always_comb begin
      case (type_sel)
         TYPE_ACCEL:    type_len = cfg.accel_len;
         TYPE_GYRO:     type_len = cfg.gyro_len;
         TYPE_MAGNET:   type_len = cfg.magnet_len;
         TYPE_QUAT:     type_len = cfg.quat_len;
         TYPE_LOCATION: type_len = cfg.location_len;
         default:       type_len = '0;
      endcase
   end

   assign byte_close = (fill_next == FILL_W'(MAX_FRAME)) ||
                       ((fill_next >= FILL_W'(2)) && (CMP_W'(fill_next) == CMP_W'(type_len)));
   assign tick_close = (idle_ff <= IDLE_W'(1));
   assign stat.close_hit = is_byte ? byte_close : tick_close;

   // Frame verdict from the collected summary registers.
   always_comb begin
      if (fill_ff == '0) begin
         emit_status = ST_NO_DATA;
      end else if (first_ff != START_CHAR) begin
         emit_status = ST_BAD_START;
      end else if (~prev_sum_ff != last_ff) begin
         emit_status = ST_CHECKSUM;
      end else begin
         emit_status = ST_OK;
      end
   end

   assign emit_ok        = (emit_status == ST_OK);
   assign stat.emit_last = !emit_ok || (FILL_W'(emit_idx_ff) + FILL_W'(1) == fill_ff);

   always_comb begin
      fill_in     = fill_ff;
      sum_in      = sum_ff;
      prev_sum_in = prev_sum_ff;
      last_in     = last_ff;
      first_in    = first_ff;
      type_in     = type_ff;
      idle_in     = idle_ff;
      emit_idx_in = emit_idx_ff;
      if (cmd.take) begin
         if (is_byte) begin
            fill_in     = fill_next;
            prev_sum_in = sum_base;
            sum_in      = sum_base + req_rx_byte;
            last_in     = req_rx_byte;
            idle_in     = cfg.timeout;
            if (wr_idx == '0) first_in = req_rx_byte;
            if (wr_idx == FILL_W'(1)) type_in = req_rx_byte;
         end else if (!tick_close) begin
            idle_in = idle_ff - IDLE_W'(1);
         end
      end
      if (cmd.emit) begin
         emit_idx_in = emit_idx_ff + IDX_W'(1);
      end
      if (cmd.finish) begin
         fill_in     = '0;
         sum_in      = '0;
         idle_in     = cfg.timeout;
         emit_idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         sum_ff      <= '0;
         idle_ff     <= RST_TIMEOUT;
         emit_idx_ff <= '0;
      end else begin
         fill_ff     <= fill_in;
         sum_ff      <= sum_in;
         idle_ff     <= idle_in;
         emit_idx_ff <= emit_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_sum_ff <= prev_sum_in;
      last_ff     <= last_in;
      first_ff    <= first_in;
      type_ff     <= type_in;
      if (cmd.take && is_byte) begin
         store_ff[wr_idx[IDX_W-1:0]] <= req_rx_byte;
      end
      if (cmd.emit) begin
         rsp_status_ff       <= emit_status;
         rsp_frame_length_ff <= OUT_LEN_W'(fill_ff);
         rsp_byte_index_ff   <= emit_ok ? OUT_IDX_W'(emit_idx_ff) : '0;
         rsp_frame_byte_ff   <= emit_ok ? store_ff[emit_idx_ff] : 8'd0;
         rsp_last_ff         <= stat.emit_last;
      end
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_frame_length = rsp_frame_length_ff;
   assign rsp_byte_index   = rsp_byte_index_ff;
   assign rsp_frame_byte   = rsp_frame_byte_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

>>> hw/rtl/ble_sensor_packet_deframer.sv
// ----------------------------------------------------------------------------
// Sensor packet deframer
// Gathers received bytes into frames, closes them on length or idle timeout,
// checks start byte and checksum, and streams out the frame or an error.
//
//   Channel | Direction | Handshake       | Carries
//   --------+-----------+-----------------+----------------------------------
//   req_ch  | in        | valid/ready     | cmd, rx_byte
//   rsp_ch  | out       | valid/ready     | status, frame_length, byte_index,
//           |           |                 | frame_byte, last
//   csr_*   | in        | write enable    | register index, write data
//
// While collecting, one byte or tick transaction is accepted every cycle.
// A transaction that closes the frame is followed by 1 result (error) or n
// results (valid frame of n bytes, up to MAX_FRAME), one per cycle through
// the single output register; input is held off until the final result is
// loaded. A stalled rsp_ch holds the result and pauses emission.
// Reset is synchronous; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module ble_sensor_packet_deframer import bspd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   bspd_req_if.sink              req_ch,
   bspd_rsp_if.source            rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   csr_cfg_type cfg;
   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   bspd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bspd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   bspd_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_cmd          (req_ch.cmd),
      .req_rx_byte      (req_ch.rx_byte),
      .cfg              (cfg),
      .cmd              (dp_cmd),
      .stat             (dp_stat),
      .rsp_status       (rsp_ch.status),
      .rsp_frame_length (rsp_ch.frame_length),
      .rsp_byte_index   (rsp_ch.byte_index),
      .rsp_frame_byte   (rsp_ch.frame_byte),
      .rsp_last         (rsp_ch.last)
   );

endmodule

>>> hw/rtl/bspd_checker.sv
// ----------------------------------------------------------------------------
// Deframer port checker
// Checks result consistency seen on the deframer's response channel.
// ----------------------------------------------------------------------------
module bspd_checker import bspd_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [4:0] rsp_frame_length,
   input logic [4:0] rsp_byte_index,
   input logic [7:0] rsp_frame_byte,
   input logic       rsp_last
);

   // A stalled result must stay put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_byte_index) && $stable(rsp_frame_byte) && $stable(rsp_last))
      else $error("response changed while stalled");

   // An error result is a single transaction at position zero.
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_last && rsp_byte_index == 5'd0 &&
      rsp_frame_byte == 8'd0)
      else $error("error result is not a lone final transaction");

   // A good frame always opens with the start character.
   a_ok_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK && rsp_byte_index == 5'd0 |->
      rsp_frame_byte == START_CHAR)
      else $error("good frame without start character");

   // The final byte of a good frame sits at frame_length - 1.
   a_ok_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK && rsp_last |->
      rsp_byte_index == rsp_frame_length - 5'd1)
      else $error("final byte index does not match frame length");

   // An empty frame reports a zero length.
   a_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NO_DATA |-> rsp_frame_length == 5'd0)
      else $error("no-data result with nonzero length");

endmodule

bind ble_sensor_packet_deframer bspd_checker u_bspd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_status       (rsp_ch.status),
   .rsp_frame_length (rsp_ch.frame_length),
   .rsp_byte_index   (rsp_ch.byte_index),
   .rsp_frame_byte   (rsp_ch.frame_byte),
   .rsp_last         (rsp_ch.last)
);
